// ----- rtl/wts_pkg.sv -----
// wts_pkg: shared types, codes and constants of the whitespace token scanner
// used by the lane, window and top level rtl files of the scanner; depends on nothing
`default_nettype none

package wts_pkg;

	// default sizes of the top level parameters
	localparam int WINDOW_BITS_DEF = 64;
	localparam int CHUNK_BYTES_DEF = 8;

	// fixed field widths of the stream words
	localparam int LEN_W  = 16;
	localparam int NB_W   = 4;
	localparam int CNT_W  = 7;
	localparam int DATA_W = 64;
	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	// byte codes of the whitespace classes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	typedef enum logic [1:0] {
		ACT_PUSH    = 2'd0,
		ACT_TOKEN   = 2'd1,
		ACT_SPACE   = 2'd2,
		ACT_CONSUME = 2'd3
	} action_e_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_BUSY     = 2'd2
	} status_e_t;

	localparam logic KIND_TOKEN = 1'b0;
	localparam logic KIND_SPACE = 1'b1;

	typedef struct packed {
		logic             valid;
		logic [LEN_W-1:0] length;
		logic             kind;
		status_e_t        status;
	} res_t;

endpackage

`default_nettype wire

// ----- rtl/wts_lane.sv -----
// wts_lane: classifies one text byte into space/tab and whitespace bits
// depends on wts_pkg for the byte codes
`default_nettype none

module wts_lane (
	input  wire logic [7:0] text_byte,
	input  wire logic       en,
	output logic            st,
	output logic            ws
);

	logic is_st;

	assign is_st = (text_byte == wts_pkg::CH_SPACE) || (text_byte == wts_pkg::CH_TAB);
	assign st    = en && is_st;
	assign ws    = en && (is_st || (text_byte == wts_pkg::CH_CR)
		|| (text_byte == wts_pkg::CH_LF));

endmodule

`default_nettype wire

// ----- rtl/wts_window.sv -----
// wts_window: merges lane class bits into the window and runs queries and consumes
// depends on wts_pkg for codes and the result struct
`default_nettype none

module wts_window #(
	parameter int WINDOW_BITS = wts_pkg::WINDOW_BITS_DEF,
	parameter int CHUNK_BYTES = wts_pkg::CHUNK_BYTES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         take,
	input  wire wts_pkg::action_e_t           action,
	input  wire logic [CHUNK_BYTES-1:0]       chunk_st,
	input  wire logic [CHUNK_BYTES-1:0]       chunk_ws,
	input  wire logic [wts_pkg::NB_W-1:0]     nbytes,
	input  wire logic [wts_pkg::CNT_W-1:0]    consume_count,
	output wts_pkg::res_t                     res
);

	localparam int AW = $clog2(WINDOW_BITS + 1);
	localparam int SW = AW + 1;
	localparam int LW = wts_pkg::LEN_W;

	logic [WINDOW_BITS-1:0] st_q, ws_q;
	logic [AW-1:0]          avail_q;
	logic                   pend_q;
	logic                   kind_q;
	logic [LW-1:0]          plen_q;

	logic [WINDOW_BITS-1:0] st_d, ws_d;
	logic [AW-1:0]          avail_d;
	logic                   pend_d;
	logic                   kind_d;
	logic [LW-1:0]          plen_d;

	logic [SW-1:0]          fill_sum;
	logic                   ovf;
	logic [WINDOW_BITS-1:0] app_st, app_ws;
	logic [WINDOW_BITS-1:0] win_st, win_ws, amask, scan_v;
	logic [AW-1:0]          win_a;
	logic [LW-1:0]          base;
	logic                   qkind;
	logic                   found;
	logic [AW-1:0]          idx, qd;
	logic [LW:0]            lsum;
	logic [LW-1:0]          qlen;
	logic [wts_pkg::CNT_W-1:0] avail_w;
	logic [AW-1:0]          cd;

	// append the chunk above the bytes already held
	assign fill_sum = SW'(avail_q) + SW'(nbytes);
	assign ovf      = fill_sum > SW'(WINDOW_BITS);
	assign app_st   = st_q | (WINDOW_BITS'(chunk_st) << avail_q);
	assign app_ws   = ws_q | (WINDOW_BITS'(chunk_ws) << avail_q);

	// a push can only continue a query, so the query sees the appended window
	assign win_st = (action == wts_pkg::ACT_PUSH) ? app_st : st_q;
	assign win_ws = (action == wts_pkg::ACT_PUSH) ? app_ws : ws_q;
	assign win_a  = (action == wts_pkg::ACT_PUSH) ? AW'(fill_sum) : avail_q;
	assign base   = pend_q ? plen_q : '0;
	assign qkind  = pend_q ? kind_q : (action == wts_pkg::ACT_SPACE);

	// token stops at first whitespace, space run stops at first non space/tab
	assign amask  = ~(~WINDOW_BITS'(0) << win_a);
	assign scan_v = (qkind == wts_pkg::KIND_SPACE) ? (~win_st & amask) : win_ws;
	assign found  = |scan_v;

	always_comb begin
		idx = '0;
		for (int i = WINDOW_BITS - 1; i >= 0; i--) begin
			if (scan_v[i]) begin
				idx = AW'(i);
			end
		end
	end

	assign qd   = found ? idx : win_a;
	assign lsum = (LW + 1)'(base) + (LW + 1)'(qd);
	assign qlen = (lsum > (LW + 1)'(wts_pkg::LEN_MAX)) ? wts_pkg::LEN_MAX : lsum[LW-1:0];

	assign avail_w = wts_pkg::CNT_W'(avail_q);
	assign cd      = (consume_count > avail_w) ? avail_q : AW'(consume_count);

	always_comb begin
		st_d       = st_q;
		ws_d       = ws_q;
		avail_d    = avail_q;
		pend_d     = pend_q;
		kind_d     = kind_q;
		plen_d     = plen_q;
		res.valid  = 1'b0;
		res.length = '0;
		res.kind   = wts_pkg::KIND_TOKEN;
		res.status = wts_pkg::ST_OK;
		if (action == wts_pkg::ACT_PUSH && ovf) begin
			res.valid  = 1'b1;
			res.status = wts_pkg::ST_OVERFLOW;
		end else if (action != wts_pkg::ACT_PUSH && pend_q) begin
			res.valid  = 1'b1;
			res.status = wts_pkg::ST_BUSY;
		end else if (action == wts_pkg::ACT_CONSUME) begin
			st_d    = st_q >> cd;
			ws_d    = ws_q >> cd;
			avail_d = avail_q - cd;
		end else if (action == wts_pkg::ACT_PUSH && !pend_q) begin
			st_d    = app_st;
			ws_d    = app_ws;
			avail_d = win_a;
		end else begin
			// query start or continuation
			st_d    = win_st >> qd;
			ws_d    = win_ws >> qd;
			avail_d = win_a - qd;
			kind_d  = qkind;
			plen_d  = qlen;
			pend_d  = !found;
			if (found) begin
				res.valid  = 1'b1;
				res.length = qlen;
				res.kind   = qkind;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= '0;
			ws_q    <= '0;
			avail_q <= '0;
			pend_q  <= 1'b0;
			kind_q  <= wts_pkg::KIND_TOKEN;
			plen_q  <= '0;
		end else if (take) begin
			st_q    <= st_d;
			ws_q    <= ws_d;
			avail_q <= avail_d;
			pend_q  <= pend_d;
			kind_q  <= kind_d;
			plen_q  <= plen_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/whitespace_token_scanner.sv -----
// whitespace_token_scanner: top level, byte lanes, window engine and output register
// depends on wts_pkg, wts_lane and wts_window
//
//  port group  dir  tdata (low bit up)                           tuser
//  s_*         in   chunk_data[63:0] chunk_bytes[67:64]          action[1:0]
//                   consume_count[74:68] zeros[79:75]
//  m_*         out  length[15:0]                                 query_kind[0] status[2:1]
//
// one word is taken every cycle while s_tready is high; its result, if any, shows on m_* the next cycle
// classification, append, first-hit search and shift are all combinational, in the cycle the word is taken
// s_tready drops only while a result is held and m_tready is low
// arst_n clears the window, counts and pending query at once, no clearing pass
`default_nettype none

module whitespace_token_scanner #(
	parameter int WINDOW_BITS = wts_pkg::WINDOW_BITS_DEF,
	parameter int CHUNK_BYTES = wts_pkg::CHUNK_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,   // chunk_data, chunk_bytes, consume_count
	input  wire logic [1:0]  s_tuser,   // action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // length
	output logic [2:0]       m_tuser    // query_kind, status
);

	logic                            take;
	wts_pkg::action_e_t              action;
	logic [wts_pkg::NB_W-1:0]        nb_raw, nb;
	logic [CHUNK_BYTES-1:0]          lane_st, lane_ws;
	wts_pkg::res_t                   res;

	logic                            out_valid_q;
	logic [wts_pkg::LEN_W-1:0]       out_len_q;
	logic                            out_kind_q;
	wts_pkg::status_e_t              out_status_q;

	assign s_tready = !out_valid_q || m_tready;
	assign take     = s_tvalid && s_tready;
	assign action   = wts_pkg::action_e_t'(s_tuser);
	assign nb_raw   = s_tdata[67:64];
	assign nb       = (nb_raw > wts_pkg::NB_W'(CHUNK_BYTES)) ?
		wts_pkg::NB_W'(CHUNK_BYTES) : nb_raw;

	for (genvar i = 0; i < CHUNK_BYTES; i++) begin : g_lane
		wts_lane u_lane (
			.text_byte (s_tdata[8*i +: 8]),
			.en        (wts_pkg::NB_W'(i) < nb),
			.st        (lane_st[i]),
			.ws        (lane_ws[i])
		);
	end

	wts_window #(
		.WINDOW_BITS (WINDOW_BITS),
		.CHUNK_BYTES (CHUNK_BYTES)
	) u_window (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.action        (action),
		.chunk_st      (lane_st),
		.chunk_ws      (lane_ws),
		.nbytes        (nb),
		.consume_count (s_tdata[74:68]),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= res.valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res.valid) begin
			out_len_q    <= res.length;
			out_kind_q   <= res.kind;
			out_status_q <= res.status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_len_q;
	assign m_tuser  = {out_status_q, out_kind_q};

endmodule

`default_nettype wire

// ----- rtl/wts_checker.sv -----
// wts_checker: port-level checks of the whitespace token scanner
// sees the top level ports only; bound to whitespace_token_scanner below
`default_nettype none

module wts_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [79:0] s_tdata,
	input wire logic [1:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic [2:0]  m_tuser
);

	logic unused_in;
	assign unused_in = s_tvalid ^ (^s_tdata) ^ (^s_tuser);

	// a held word keeps its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	// no status code beyond busy
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[2:1] != 2'd3)
		else $error("undefined status code");

	// error words carry zero length and token kind
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:1] != 2'd0 |-> m_tdata == 16'd0 && !m_tuser[0])
		else $error("error word with nonzero payload");

	// an empty output stage never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output stage");

endmodule

bind whitespace_token_scanner wts_checker u_wts_checker (.*);

`default_nettype wire
